[rtl/strb_pkg.sv]
// Shared types and constants for the serial ring buffer engine.
`default_nettype none

package strb_pkg;

    // Default ring depths; both must be powers of two.
    localparam int unsigned RX_DEPTH_DEF = 2048;
    localparam int unsigned TX_DEPTH_DEF = 2048;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEVEL_W = 12;

    typedef enum logic [1:0] {
        KIND_HOST_WRITE = 2'd0,
        KIND_HOST_READ  = 2'd1,
        KIND_LINE_RX    = 2'd2,
        KIND_TX_EMPTY   = 2'd3
    } kind_t;

    // Result fields held between the RAM read issue and the output register.
    typedef struct packed {
        logic                send_valid;
        logic                send_from_ram;
        logic [BYTE_W-1:0]   bypass_byte;
        logic                read_from_ram;
        logic                ok;
        logic [LEVEL_W-1:0]  rx_level;
        logic                line_idle;
    } stage_t;

endpackage

`default_nettype wire

[rtl/strb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module strb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/serial_tx_rx_ring_buffer_engine_core.sv]
// Top level of the serial ring buffer engine: pointer logic, RAMs and result pipeline.
`default_nettype none

// Buffers a serial port in both directions with a receive ring and a transmit
// ring, each RX_DEPTH / TX_DEPTH bytes deep (powers of two). Each request names
// one event: host write, host read, byte received from the line, or
// transmitter empty, and produces exactly one result. A host write while the
// line is idle goes straight out on line_send_byte; otherwise it is queued and
// fails (ok=0) on a full transmit ring. A host read pops the receive ring and
// fails on an empty one. A received byte is dropped with ok=0 on a full ring.
// Every result carries the receive fill level and the line idle flag after the
// event. The block takes one request per cycle unless stalled by back-pressure,
// and each result passes the middle stage on its way to the output register:
// pointers and counts update at accept while the ring RAM is read, then the
// registered RAM data and the held status form the result in the output
// register. Back-pressure on the result channel stalls the input channel only
// when both internal stages are full. The ring RAMs need no clearing after
// reset: an entry is read only after being written.
module serial_tx_rx_ring_buffer_engine_core #(
    parameter int unsigned RX_DEPTH = strb_pkg::RX_DEPTH_DEF,
    parameter int unsigned TX_DEPTH = strb_pkg::TX_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    kind,
    input  wire logic [strb_pkg::BYTE_W-1:0]   data_byte,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               line_send_valid,
    output logic      [strb_pkg::BYTE_W-1:0]   line_send_byte,
    output logic      [strb_pkg::BYTE_W-1:0]   read_byte,
    output logic                               ok,
    output logic      [strb_pkg::LEVEL_W-1:0]  rx_level,
    output logic                               line_idle
);

    localparam int unsigned RX_AW = $clog2(RX_DEPTH);
    localparam int unsigned RX_CW = $clog2(RX_DEPTH + 1);
    localparam int unsigned TX_AW = $clog2(TX_DEPTH);
    localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);
    localparam logic [RX_CW-1:0] RX_FULL = RX_CW'(RX_DEPTH);
    localparam logic [TX_CW-1:0] TX_FULL = TX_CW'(TX_DEPTH);

    // Ring pointers and fill levels.
    logic [RX_AW-1:0] rx_head_reg,  rx_head_next;
    logic [RX_AW-1:0] rx_tail_reg,  rx_tail_next;
    logic [RX_CW-1:0] rx_count_reg, rx_count_next;
    logic [TX_AW-1:0] tx_head_reg,  tx_head_next;
    logic [TX_AW-1:0] tx_tail_reg,  tx_tail_next;
    logic [TX_CW-1:0] tx_count_reg, tx_count_next;
    logic             tx_idle_reg,  tx_idle_next;

    // Middle stage: status waiting for the RAM read data.
    logic             s1_valid_reg, s1_valid_next;
    strb_pkg::stage_t s1_reg,       s1_next;

    // Output register.
    logic                         out_valid_reg,  out_valid_next;
    logic                         send_valid_reg, send_valid_next;
    logic [strb_pkg::BYTE_W-1:0]  send_byte_reg,  send_byte_next;
    logic [strb_pkg::BYTE_W-1:0]  read_byte_reg,  read_byte_next;
    logic                         ok_reg,         ok_next;
    logic [strb_pkg::LEVEL_W-1:0] level_reg,      level_next;
    logic                         idle_reg,       idle_next;

    // RAM ports.
    logic                        rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
    logic [strb_pkg::BYTE_W-1:0] rx_rd_data, tx_rd_data;

    logic accept;
    logic s1_advance;

    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign accept     = in_valid && in_ready;

    strb_ram #(
        .WIDTH (strb_pkg::BYTE_W),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_tail_reg),
        .wr_data (data_byte),
        .rd_en   (rx_rd_en),
        .rd_addr (rx_head_reg),
        .rd_data (rx_rd_data)
    );

    strb_ram #(
        .WIDTH (strb_pkg::BYTE_W),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_tail_reg),
        .wr_data (data_byte),
        .rd_en   (tx_rd_en),
        .rd_addr (tx_head_reg),
        .rd_data (tx_rd_data)
    );

    // Event decode: update pointers and issue the RAM access at accept.
    always_comb
    begin
        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        rx_count_next = rx_count_reg;
        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        tx_count_next = tx_count_reg;
        tx_idle_next  = tx_idle_reg;
        rx_wr_en      = 1'b0;
        rx_rd_en      = 1'b0;
        tx_wr_en      = 1'b0;
        tx_rd_en      = 1'b0;
        s1_next       = '0;

        if (accept)
        begin
            unique case (strb_pkg::kind_t'(kind))
                strb_pkg::KIND_HOST_WRITE:
                begin
                    if (tx_idle_reg)
                    begin
                        // Line idle: bypass the ring.
                        tx_idle_next        = 1'b0;
                        s1_next.send_valid  = 1'b1;
                        s1_next.bypass_byte = data_byte;
                        s1_next.ok          = 1'b1;
                    end
                    else if (tx_count_reg != TX_FULL)
                    begin
                        tx_wr_en      = 1'b1;
                        tx_tail_next  = tx_tail_reg + 1'b1;
                        tx_count_next = tx_count_reg + 1'b1;
                        s1_next.ok    = 1'b1;
                    end
                end
                strb_pkg::KIND_HOST_READ:
                begin
                    if (rx_count_reg != '0)
                    begin
                        rx_rd_en              = 1'b1;
                        rx_head_next          = rx_head_reg + 1'b1;
                        rx_count_next         = rx_count_reg - 1'b1;
                        s1_next.read_from_ram = 1'b1;
                        s1_next.ok            = 1'b1;
                    end
                end
                strb_pkg::KIND_LINE_RX:
                begin
                    if (rx_count_reg != RX_FULL)
                    begin
                        rx_wr_en      = 1'b1;
                        rx_tail_next  = rx_tail_reg + 1'b1;
                        rx_count_next = rx_count_reg + 1'b1;
                        s1_next.ok    = 1'b1;
                    end
                end
                strb_pkg::KIND_TX_EMPTY:
                begin
                    if (tx_count_reg != '0)
                    begin
                        // Send the oldest queued byte; line stays busy.
                        tx_rd_en              = 1'b1;
                        tx_head_next          = tx_head_reg + 1'b1;
                        tx_count_next         = tx_count_reg - 1'b1;
                        tx_idle_next          = 1'b0;
                        s1_next.send_valid    = 1'b1;
                        s1_next.send_from_ram = 1'b1;
                    end
                    else
                    begin
                        tx_idle_next = 1'b1;
                    end
                end
            endcase
        end

        s1_next.rx_level  = strb_pkg::LEVEL_W'(rx_count_next);
        s1_next.line_idle = tx_idle_next;
    end

    // Pipeline advance: the middle stage loads whenever it is empty or moving on,
    // and holds while the output register is stuck; the RAM read data holds with
    // it since no new read is issued.
    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        out_valid_next  = out_valid_reg;
        send_valid_next = send_valid_reg;
        send_byte_next  = send_byte_reg;
        read_byte_next  = read_byte_reg;
        ok_next         = ok_reg;
        level_next      = level_reg;
        idle_next       = idle_reg;

        if (in_ready)
        begin
            s1_valid_next = accept;
        end

        if (s1_advance)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                send_valid_next = s1_reg.send_valid;
                send_byte_next  = s1_reg.send_from_ram ? tx_rd_data : s1_reg.bypass_byte;
                read_byte_next  = s1_reg.read_from_ram ? rx_rd_data : '0;
                ok_next         = s1_reg.ok;
                level_next      = s1_reg.rx_level;
                idle_next       = s1_reg.line_idle;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            rx_count_reg  <= '0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            tx_count_reg  <= '0;
            tx_idle_reg   <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rx_head_reg   <= rx_head_next;
            rx_tail_reg   <= rx_tail_next;
            rx_count_reg  <= rx_count_next;
            tx_head_reg   <= tx_head_next;
            tx_tail_reg   <= tx_tail_next;
            tx_count_reg  <= tx_count_next;
            tx_idle_reg   <= tx_idle_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_reg <= s1_next;
        end
        send_valid_reg <= send_valid_next;
        send_byte_reg  <= send_byte_next;
        read_byte_reg  <= read_byte_next;
        ok_reg         <= ok_next;
        level_reg      <= level_next;
        idle_reg       <= idle_next;
    end

    assign out_valid       = out_valid_reg;
    assign line_send_valid = send_valid_reg;
    assign line_send_byte  = send_byte_reg;
    assign read_byte       = read_byte_reg;
    assign ok              = ok_reg;
    assign rx_level        = level_reg;
    assign line_idle       = idle_reg;

endmodule

`default_nettype wire

[tb/tb_serial_tx_rx_ring_buffer_engine_core.sv]
// Self-checking testbench for the serial ring buffer engine core.
`timescale 1ns / 1ps

module tb_serial_tx_rx_ring_buffer_engine_core;

    localparam int unsigned RXD          = strb_pkg::RX_DEPTH_DEF;
    localparam int unsigned TXD          = strb_pkg::TX_DEPTH_DEF;
    localparam int unsigned RX_PTR_W     = $clog2(RXD);
    localparam int unsigned TX_PTR_W     = $clog2(TXD);
    localparam int unsigned IDLE_PCT     = 17;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned MAX_REPORTS  = 10;

    // One request as the sender sees it.
    typedef struct {
        strb_pkg::kind_t             k;
        logic [strb_pkg::BYTE_W-1:0] b;
    } uart_req_t;

    // One result, in port order.
    typedef struct packed {
        logic                         send_valid;
        logic [strb_pkg::BYTE_W-1:0]  send_byte;
        logic [strb_pkg::BYTE_W-1:0]  rd_byte;
        logic                         ok;
        logic [strb_pkg::LEVEL_W-1:0] level;
        logic                         idle;
    } uart_res_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    wire                          in_ready;
    logic [1:0]                   kind      = strb_pkg::KIND_HOST_WRITE;
    logic [strb_pkg::BYTE_W-1:0]  data_byte = '0;
    wire                          out_valid;
    logic                         out_ready = 1'b0;
    wire                          line_send_valid;
    wire  [strb_pkg::BYTE_W-1:0]  line_send_byte;
    wire  [strb_pkg::BYTE_W-1:0]  read_byte;
    wire                          ok;
    wire  [strb_pkg::LEVEL_W-1:0] rx_level;
    wire                          line_idle;

    // Requests waiting to be offered, and results still owed by the block.
    uart_req_t pending_events[$];
    uart_res_t expected_results[$];
    uart_req_t cur_req;

    // Stimulus controls: steady turns idling off on both sides; bumping
    // hold_token makes the receiver hold off for HOLD_CYCLES.
    logic steady      = 1'b0;
    int   hold_token  = 0;
    int   hold_seen   = 0;
    int   hold_left   = 0;
    int   mismatch_cnt = 0;
    int   cycle_count  = 0;

    // Private copy of the engine state.
    logic [strb_pkg::BYTE_W-1:0]  rx_ring [RXD];
    logic [strb_pkg::BYTE_W-1:0]  tx_ring [TXD];
    logic [RX_PTR_W-1:0]          rx_rd = '0;
    logic [RX_PTR_W-1:0]          rx_wr = '0;
    logic [TX_PTR_W-1:0]          tx_rd = '0;
    logic [TX_PTR_W-1:0]          tx_wr = '0;
    logic [strb_pkg::LEVEL_W-1:0] rx_fill = '0;
    logic [strb_pkg::LEVEL_W-1:0] tx_fill = '0;
    logic                         tx_line_idle = 1'b1;

    serial_tx_rx_ring_buffer_engine_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .line_send_valid (line_send_valid),
        .line_send_byte  (line_send_byte),
        .read_byte       (read_byte),
        .ok              (ok),
        .rx_level        (rx_level),
        .line_idle       (line_idle)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one request to the private state and return the result it owes.
    function automatic uart_res_t predict_uart_event(uart_req_t r);
        uart_res_t res;
        res = '0;
        case (r.k)
            strb_pkg::KIND_HOST_WRITE:
            begin
                if (tx_line_idle)
                begin
                    // Idle line: bypass the ring and send at once.
                    tx_line_idle   = 1'b0;
                    res.send_valid = 1'b1;
                    res.send_byte  = r.b;
                    res.ok         = 1'b1;
                end
                else if (tx_fill < TXD)
                begin
                    tx_ring[tx_wr] = r.b;
                    tx_wr          = tx_wr + 1'b1;
                    tx_fill        = tx_fill + 1'b1;
                    res.ok         = 1'b1;
                end
            end
            strb_pkg::KIND_HOST_READ:
            begin
                if (rx_fill != 0)
                begin
                    res.rd_byte = rx_ring[rx_rd];
                    rx_rd       = rx_rd + 1'b1;
                    rx_fill     = rx_fill - 1'b1;
                    res.ok      = 1'b1;
                end
            end
            strb_pkg::KIND_LINE_RX:
            begin
                if (rx_fill < RXD)
                begin
                    rx_ring[rx_wr] = r.b;
                    rx_wr          = rx_wr + 1'b1;
                    rx_fill        = rx_fill + 1'b1;
                    res.ok         = 1'b1;
                end
            end
            default:
            begin
                // Transmitter empty: send the oldest queued byte, or go idle.
                if (tx_fill != 0)
                begin
                    res.send_valid = 1'b1;
                    res.send_byte  = tx_ring[tx_rd];
                    tx_rd          = tx_rd + 1'b1;
                    tx_fill        = tx_fill - 1'b1;
                    tx_line_idle   = 1'b0;
                end
                else
                begin
                    tx_line_idle = 1'b1;
                end
            end
        endcase
        res.level = rx_fill;
        res.idle  = tx_line_idle;
        return res;
    endfunction

    // Render one result for a report line.
    function automatic string fmt_res(uart_res_t r);
        return $sformatf("send=%0d/%02h rd=%02h ok=%0d lvl=%0d idle=%0d",
            r.send_valid, r.send_byte, r.rd_byte, r.ok, r.level, r.idle);
    endfunction

    // Count a failure; report only the first few.
    task automatic log_failure(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Request driver: predict on accept, then offer the next pending request
    // or idle at random. Valid is never dropped while a request is waiting.
    always @(posedge clk)
    begin : drive_requests
        uart_req_t nxt;
        logic      accepted;
        if (rst_n)
        begin
            accepted = in_valid && in_ready;
            if (accepted)
                expected_results.push_back(predict_uart_event(cur_req));
            if (!in_valid || accepted)
            begin
                if (pending_events.size() != 0 &&
                    (steady || $urandom_range(99, 0) >= IDLE_PCT))
                begin
                    nxt = pending_events.pop_front();
                    cur_req   <= nxt;
                    kind      <= nxt.k;
                    data_byte <= nxt.b;
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted result with the oldest
    // expectation, then pick the next ready value.
    always @(posedge clk)
    begin : watch_results
        uart_res_t got;
        uart_res_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {line_send_valid, line_send_byte, read_byte, ok, rx_level, line_idle};
                if (expected_results.size() == 0)
                begin
                    log_failure({"unexpected result: ", fmt_res(got)});
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.send_valid !== want.send_valid || got.send_byte !== want.send_byte ||
                        got.rd_byte !== want.rd_byte || got.ok !== want.ok ||
                        got.level !== want.level || got.idle !== want.idle)
                        log_failure({"mismatch: exp ", fmt_res(want), ", got ", fmt_res(got)});
                end
            end
            // Start a long hold-off when the stimulus asks for one.
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** serial_tx_rx_ring_buffer_engine_core: FAILED **");
            $finish;
        end
    end

    function automatic logic [strb_pkg::BYTE_W-1:0] rand_byte();
        return strb_pkg::BYTE_W'($urandom_range(255, 0));
    endfunction

    task automatic add_req(input strb_pkg::kind_t k, input logic [strb_pkg::BYTE_W-1:0] b);
        uart_req_t r;
        r.k = k;
        r.b = b;
        pending_events.push_back(r);
    endtask

    // Hold the sender until every request is accepted and answered.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_events.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // Random bursts of one kind each, so the rings rise and fall.
    task automatic add_random_bursts(input int n);
        int              cnt;
        int              len;
        strb_pkg::kind_t k;
        cnt = 0;
        while (cnt < n)
        begin
            k   = strb_pkg::kind_t'($urandom_range(3, 0));
            len = $urandom_range(8, 1);
            repeat (len)
                add_req(k, rand_byte());
            cnt += len;
        end
    endtask

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: idle-line events, empty read, bypass, queue, drain, extremes.
        add_req(strb_pkg::KIND_TX_EMPTY,   8'h00);   // transmitter empty while already idle
        add_req(strb_pkg::KIND_HOST_READ,  8'hFF);   // read from empty receive ring
        add_req(strb_pkg::KIND_HOST_WRITE, 8'h00);   // write while idle bypasses the ring
        add_req(strb_pkg::KIND_HOST_WRITE, 8'hFF);   // queued
        add_req(strb_pkg::KIND_HOST_WRITE, 8'hA5);   // queued
        add_req(strb_pkg::KIND_TX_EMPTY,   8'hFF);   // send oldest queued byte
        add_req(strb_pkg::KIND_TX_EMPTY,   8'h00);
        add_req(strb_pkg::KIND_TX_EMPTY,   8'h00);   // nothing queued: line goes idle
        add_req(strb_pkg::KIND_LINE_RX,    8'h00);
        add_req(strb_pkg::KIND_LINE_RX,    8'hFF);
        add_req(strb_pkg::KIND_LINE_RX,    8'h5A);
        add_req(strb_pkg::KIND_HOST_READ,  8'h00);
        add_req(strb_pkg::KIND_HOST_READ,  8'h00);
        add_req(strb_pkg::KIND_HOST_READ,  8'h00);
        add_req(strb_pkg::KIND_HOST_READ,  8'h00);   // empty again
        add_req(strb_pkg::KIND_HOST_WRITE, 8'h3C);
        add_req(strb_pkg::KIND_TX_EMPTY,   8'h00);
        add_req(strb_pkg::KIND_TX_EMPTY,   8'hC3);
        wait_quiet();

        // Receive ring to full and past it while the receiver holds off,
        // then drain it past empty; both pointers wrap.
        steady = 1'b1;
        hold_token++;
        repeat (RXD + 1) add_req(strb_pkg::KIND_LINE_RX, rand_byte());
        repeat (2) add_req(strb_pkg::KIND_HOST_READ, rand_byte());
        repeat (3) add_req(strb_pkg::KIND_LINE_RX, rand_byte());
        repeat (RXD + 2) add_req(strb_pkg::KIND_HOST_READ, rand_byte());
        wait_quiet();

        // Transmit ring to full and past it, then drain until the line idles.
        steady = 1'b0;
        add_req(strb_pkg::KIND_HOST_WRITE, rand_byte());
        repeat (TXD + 1) add_req(strb_pkg::KIND_HOST_WRITE, rand_byte());
        hold_token++;
        repeat (TXD + 2) add_req(strb_pkg::KIND_TX_EMPTY, rand_byte());
        wait_quiet();

        // Random traffic: a stretch with no idling, then the normal mix.
        steady = 1'b1;
        add_random_bursts(400);
        wait_quiet();
        steady = 1'b0;
        add_random_bursts(600);
        wait_quiet();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0)
            $display("** serial_tx_rx_ring_buffer_engine_core: PASSED **");
        else
            $display("** serial_tx_rx_ring_buffer_engine_core: FAILED **");
        $finish;
    end

endmodule
